@@ rtl/dtps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared widths, register indexes, queue word type and schedule tables.
// ----------------------------------------------------------------------------
package dtps_pkg;

    localparam int RATIO_W   = 16;
    localparam int SPEED_W   = 24;
    localparam int TORQUE_W  = 32;
    localparam int PITCH_W   = 16;
    localparam int POWER_W   = 27;
    localparam int EFF_W     = 17;
    localparam int RSPD_W    = 24;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 2;
    localparam int SEG_W     = 4;
    localparam int WT_W      = 17;
    localparam int GAIN_W    = 23;
    localparam int PTAB_W    = 14;
    localparam int NUM_W     = 44;
    localparam int DEN_W     = 41;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSPD  = 2'd2;

    localparam logic [POWER_W-1:0] POWER_RST = 27'd10000000;
    localparam logic [EFF_W-1:0]   EFF_RST   = 17'd61604;
    localparam logic [RSPD_W-1:0]  RSPD_RST  = 24'd3292528;

    localparam logic [PITCH_W-1:0]  PITCH_MAX  = 16'd9518;
    localparam logic [TORQUE_W-1:0] TORQUE_SAT = 32'hFFFF_FFFF;

    // One queue word: raw fields plus table segment and upper weight
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [SPEED_W-1:0] speed;
        logic [SEG_W-1:0]   seg;
        logic [WT_W-1:0]    wt;
    } t_item;

    // Gain table, Q7.16
    function automatic logic [GAIN_W-1:0] gain_at(input logic [SEG_W-1:0] idx);
        logic [GAIN_W-1:0] v;
        case (idx)
            4'd0:    v = 23'd5938054;
            4'd1:    v = 23'd5643692;
            4'd2:    v = 23'd5346122;
            4'd3:    v = 23'd5049612;
            4'd4:    v = 23'd4750894;
            4'd5:    v = 23'd4460651;
            4'd6:    v = 23'd4162373;
            4'd7:    v = 23'd3864704;
            4'd8:    v = 23'd3569381;
            4'd9:    v = 23'd3269707;
            4'd10:   v = 23'd2975458;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Minimum pitch table, Q0.16 radians
    function automatic logic [PTAB_W-1:0] pitch_at(input logic [SEG_W-1:0] idx);
        logic [PTAB_W-1:0] v;
        case (idx)
            4'd0:    v = 14'd0;
            4'd1:    v = 14'd2585;
            4'd2:    v = 14'd3838;
            4'd3:    v = 14'd4832;
            4'd4:    v = 14'd5686;
            4'd5:    v = 14'd6430;
            4'd6:    v = 14'd7133;
            4'd7:    v = 14'd7784;
            4'd8:    v = 14'd8390;
            4'd9:    v = 14'd8972;
            4'd10:   v = 14'd9518;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/dtps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_front
// Input register; splits the ratio into table segment and weight.
// ----------------------------------------------------------------------------
module dtps_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dtps_pkg::RATIO_W-1:0]  i_ratio,
    input  logic [dtps_pkg::SPEED_W-1:0]  i_speed,
    output logic                          o_push,
    output dtps_pkg::t_item               o_item,
    input  logic                          i_full
);

    logic                         r_v;
    logic [dtps_pkg::RATIO_W-1:0] r_ratio;
    logic [dtps_pkg::SPEED_W-1:0] r_speed;
    logic [20:0]                  w_pos;
    logic                         w_lim;

    assign o_stall = r_v && i_full;
    assign o_push  = r_v && !i_full;

    // Hold the word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ratio <= i_ratio;
            r_speed <= i_speed;
        end
    end

    // Table position is ratio * 20; ratios of one half and up pin to the last point
    assign w_pos = {1'b0, r_ratio, 4'b0} + {3'b0, r_ratio, 2'b0};
    assign w_lim = r_ratio[dtps_pkg::RATIO_W-1];

    always_comb begin
        o_item.ratio = r_ratio;
        o_item.speed = r_speed;
        o_item.seg   = w_lim ? 4'd9 : w_pos[19:16];
        o_item.wt    = w_lim ? 17'h10000 : {1'b0, w_pos[15:0]};
    end

endmodule

@@ rtl/dtps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_queue
// Short word queue between the front and back sections.
// ----------------------------------------------------------------------------
module dtps_queue #(
    parameter int DEPTH = dtps_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtps_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output dtps_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dtps_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    // Write the word at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/dtps_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_div
// Radix-2 restoring divider: round(num * 2^24 / den), saturating to 32 bits.
// ----------------------------------------------------------------------------
module dtps_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dtps_pkg::NUM_W-1:0]     i_num,
    input  logic [dtps_pkg::DEN_W-1:0]     i_den,
    output logic                           o_busy,
    output logic [dtps_pkg::TORQUE_W-1:0]  o_quot
);

    localparam int CW = dtps_pkg::DIV_CNT_W;

    logic                          r_busy;
    logic                          r_sat;
    logic [CW-1:0]                 r_cnt;
    logic [dtps_pkg::DEN_W-1:0]    r_rem;
    logic [dtps_pkg::DEN_W-1:0]    r_den;
    logic [dtps_pkg::TORQUE_W-1:0] r_q;
    logic [7:0]                    r_low;
    logic                          w_ovf;
    logic [dtps_pkg::DEN_W:0]      w_trial;
    logic                          w_ge;
    logic                          w_rnd;

    // Quotient of 256 or more, or a zero divisor, saturates at once
    assign w_ovf   = ({5'b0, i_num} >= {i_den, 8'b0}) || (i_den == '0);
    assign w_trial = {r_rem, r_low[7]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_ovf;
            r_sat  <= w_ovf;
            r_cnt  <= CW'(dtps_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {5'b0, i_num[dtps_pkg::NUM_W-1:8]};
            r_low <= i_num[7:0];
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? dtps_pkg::DEN_W'(w_trial - {1'b0, r_den})
                          : w_trial[dtps_pkg::DEN_W-1:0];
            r_low <= {r_low[6:0], 1'b0};
            r_q   <= {r_q[dtps_pkg::TORQUE_W-2:0], w_ge};
        end
    end

    // Round half up on the final remainder
    assign w_rnd  = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quot = (r_sat || (w_rnd && (&r_q))) ? dtps_pkg::TORQUE_SAT
                                                 : r_q + {31'b0, w_rnd};

endmodule

@@ rtl/dtps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_back
// Interpolates gain and pitch, forms the three torque limits, holds result.
// ----------------------------------------------------------------------------
module dtps_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_qvalid,
    output logic                           o_pop,
    input  dtps_pkg::t_item                i_item,
    input  logic [dtps_pkg::POWER_W-1:0]   i_power,
    input  logic [dtps_pkg::EFF_W-1:0]     i_eff,
    input  logic [dtps_pkg::RSPD_W-1:0]    i_rspd,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dtps_pkg::TORQUE_W-1:0]  o_torque,
    output logic [dtps_pkg::PITCH_W-1:0]   o_pitch
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PROD = 5'b00100,
        S_KW   = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    dtps_pkg::t_item               r_item;
    logic [39:0]                   r_g0, r_g1;
    logic [30:0]                   r_p0, r_p1;
    logic [47:0]                   r_ww;
    logic [dtps_pkg::NUM_W-1:0]    r_np;
    logic [dtps_pkg::DEN_W-1:0]    r_dp, r_dm;
    logic [dtps_pkg::GAIN_W-1:0]   r_k;
    logic [31:0]                   r_w2;
    logic [dtps_pkg::PITCH_W-1:0]  r_pit;
    logic [54:0]                   r_kw;
    logic                          r_ov;
    logic [dtps_pkg::TORQUE_W-1:0] r_torque;
    logic [dtps_pkg::PITCH_W-1:0]  r_pitch;

    logic [dtps_pkg::SEG_W-1:0]    w_seg1;
    logic [dtps_pkg::WT_W-1:0]     w_wlo;
    logic                          w_start;
    logic                          w_busy0, w_busy1;
    logic [dtps_pkg::TORQUE_W-1:0] w_tpow, w_tmax, w_topt, w_tmin;
    logic                          w_load;

    assign o_pop   = (r_state == S_IDLE) && i_qvalid;
    assign w_start = (r_state == S_PROD);
    assign w_seg1  = r_item.seg + 1'b1;
    assign w_wlo   = 17'h10000 - r_item.wt;

    // Gain rounding: product is Q7.16 * Q16.16, keep Q23.8
    assign w_topt = {1'b0, r_kw[54:24]} + {31'b0, r_kw[23]};
    assign w_tmin = (w_topt < w_tpow) ? ((w_topt < w_tmax) ? w_topt : w_tmax)
                                      : ((w_tpow < w_tmax) ? w_tpow : w_tmax);
    assign w_load = (r_state == S_DIV) && !w_busy0 && !w_busy1 && (!r_ov || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_qvalid) n_state = S_MUL;
            S_MUL:   n_state = S_PROD;
            S_PROD:  n_state = S_KW;
            S_KW:    n_state = S_DIV;
            S_DIV:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath steps
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_MUL) begin
            r_g0 <= dtps_pkg::gain_at(r_item.seg) * w_wlo;
            r_g1 <= dtps_pkg::gain_at(w_seg1) * r_item.wt;
            r_p0 <= dtps_pkg::pitch_at(r_item.seg) * w_wlo;
            r_p1 <= dtps_pkg::pitch_at(w_seg1) * r_item.wt;
            r_ww <= r_item.speed * r_item.speed;
            r_np <= i_power * (17'h10000 - {1'b0, r_item.ratio});
            r_dp <= r_item.speed * i_eff;
            r_dm <= i_rspd * i_eff;
        end
        if (r_state == S_PROD) begin
            r_k   <= dtps_pkg::GAIN_W'(({1'b0, r_g0} + {1'b0, r_g1} + 41'd32768) >> 16);
            r_w2  <= 32'(({1'b0, r_ww} + 49'd32768) >> 16);
            r_pit <= dtps_pkg::PITCH_W'(({1'b0, r_p0} + {1'b0, r_p1} + 32'd32768) >> 16);
        end
        if (r_state == S_KW) begin
            r_kw <= r_k * r_w2;
        end
    end

    // Output word register, drops when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_torque <= w_tmin;
            r_pitch  <= r_pit;
        end
    end

    // Derated power over speed
    dtps_div u_div_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_np),
        .i_den   (r_dp),
        .o_busy  (w_busy0),
        .o_quot  (w_tpow)
    );

    // Rated power over rated speed
    dtps_div u_div_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({1'b0, i_power, 16'b0}),
        .i_den   (r_dm),
        .o_busy  (w_busy1),
        .o_quot  (w_tmax)
    );

    assign o_valid  = r_ov;
    assign o_torque = r_torque;
    assign o_pitch  = r_pitch;

endmodule

@@ rtl/derated_torque_pitch_schedule.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// derated_torque_pitch_schedule
// Torque demand and minimum pitch from derating ratio and generator speed.
// ----------------------------------------------------------------------------
// Input words (ratio, speed) arrive on i_valid / o_stall; results leave on
// o_valid / i_stall, one result word per input word, in order.
// A word is taken at a clock edge with valid high and stall low.
// The front registers each word and splits the ratio into a table segment
// and weight, then pushes it into a short queue. The back pops one word at
// a time, runs the table and speed products, and two 32-step dividers for
// the power limits in parallel.
// The back pops the next word only once both dividers have finished their
// 32 iterations.
// The back keeps working while a finished word waits in the output
// register; when i_stall holds, the queue fills and o_stall rises.
// Reset (synchronous, active low) empties the queue and output register
// and restores the three configuration registers to their defaults.
// Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module derated_torque_pitch_schedule #(
    parameter int QDEPTH = dtps_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dtps_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dtps_pkg::RATIO_W-1:0]    i_derating_ratio,
    input  logic [dtps_pkg::SPEED_W-1:0]    i_generator_speed,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dtps_pkg::TORQUE_W-1:0]   o_torque_demand,
    output logic [dtps_pkg::PITCH_W-1:0]    o_pitch_minimum
);

    logic [dtps_pkg::POWER_W-1:0] r_power;
    logic [dtps_pkg::EFF_W-1:0]   r_eff;
    logic [dtps_pkg::RSPD_W-1:0]  r_rspd;

    dtps_pkg::t_item w_fitem, w_qitem;
    logic            w_push, w_full, w_qvalid, w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= dtps_pkg::POWER_RST;
            r_eff   <= dtps_pkg::EFF_RST;
            r_rspd  <= dtps_pkg::RSPD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dtps_pkg::CFG_POWER: r_power <= i_cfg_data;
                dtps_pkg::CFG_EFF:   r_eff   <= i_cfg_data[dtps_pkg::EFF_W-1:0];
                dtps_pkg::CFG_RSPD:  r_rspd  <= i_cfg_data[dtps_pkg::RSPD_W-1:0];
                default: ;
            endcase
        end
    end

    dtps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ratio (i_derating_ratio),
        .i_speed (i_generator_speed),
        .o_push  (w_push),
        .o_item  (w_fitem),
        .i_full  (w_full)
    );

    dtps_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_item  (w_qitem)
    );

    dtps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (w_qvalid),
        .o_pop    (w_pop),
        .i_item   (w_qitem),
        .i_power  (r_power),
        .i_eff    (r_eff),
        .i_rspd   (r_rspd),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_torque (o_torque_demand),
        .o_pitch  (o_pitch_minimum)
    );

endmodule

@@ rtl/dtps_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_chk
// Port-level checks for the torque and pitch schedule.
// ----------------------------------------------------------------------------
module dtps_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [dtps_pkg::TORQUE_W-1:0]  o_torque_demand,
    input logic [dtps_pkg::PITCH_W-1:0]   o_pitch_minimum
);

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_torque_demand)
                               && $stable(o_pitch_minimum))
        else $error("stalled result word changed");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset empties the input register
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // Pitch never exceeds the last table point
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_minimum <= dtps_pkg::PITCH_MAX)
        else $error("pitch above table range");

endmodule

bind derated_torque_pitch_schedule dtps_chk u_chk (.*);
